// ----- design/wsfd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants for the websocket frame decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	localparam int KIND_W    = 4;
	localparam int PLEN_W    = 32;

	// frame kinds reported with frame_end
	localparam logic [KIND_W-1:0] KIND_TEXT       = 4'd0;
	localparam logic [KIND_W-1:0] KIND_TEXT_FRAG  = 4'd1;
	localparam logic [KIND_W-1:0] KIND_BIN        = 4'd2;
	localparam logic [KIND_W-1:0] KIND_BIN_FRAG   = 4'd3;
	localparam logic [KIND_W-1:0] KIND_PING       = 4'd4;
	localparam logic [KIND_W-1:0] KIND_PONG       = 4'd5;
	localparam logic [KIND_W-1:0] KIND_BAD_OP     = 4'd6;
	localparam logic [KIND_W-1:0] KIND_INCOMPLETE = 4'd7;
	localparam logic [KIND_W-1:0] KIND_TOO_LONG   = 4'd8;

	// opcodes
	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	// 7-bit length field codes
	localparam logic [6:0] LEN7_MAX   = 7'd125;
	localparam logic [6:0] LEN7_EXT16 = 7'd126;

	localparam logic [3:0] EXT_BYTES_16 = 4'd2;
	localparam logic [3:0] EXT_BYTES_64 = 4'd8;

	typedef struct packed {
		logic              has_byte;
		logic [7:0]        data_byte;
		logic              frame_end;
		logic [KIND_W-1:0] frame_kind;
		logic [PLEN_W-1:0] frame_len;
	} wsfd_result_t;

	function automatic logic [KIND_W-1:0] kind_of(input logic fin, input logic [3:0] opcode);
		logic [KIND_W-1:0] k;
		case (opcode)
			OP_CONT, OP_TEXT: k = fin ? KIND_TEXT : KIND_TEXT_FRAG;
			OP_BINARY:        k = fin ? KIND_BIN : KIND_BIN_FRAG;
			OP_PING:          k = KIND_PING;
			OP_PONG:          k = KIND_PONG;
			default:          k = KIND_BAD_OP;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

// ----- design/websocket_frame_decoder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_decoder_core
// Byte-serial websocket frame decoder: header parse, mask key capture and
// payload unmasking, with frame kind and length on the closing result.
// ----------------------------------------------------------------------------
// a byte's result passes through the input register, then the result register
// throughput: one byte per cycle with out_ready high; parse state updates once per byte
// while a result waits, a byte is taken only into an empty input register
// reset: asynchronous, clears both valid flags and returns the parse state to the
//   first header byte
module websocket_frame_decoder_core #(
	parameter int LEN_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    rx_byte,
	input  wire logic                          buffer_end,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               has_byte,
	output logic [7:0]                         data_byte,
	output logic                               frame_end,
	output logic [wsfd_pkg::KIND_W-1:0]        frame_kind,
	output logic [wsfd_pkg::PLEN_W-1:0]        frame_len
);
	import wsfd_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         out_valid_q;
	wsfd_result_t out_q;
	logic         stall;
	logic         step;
	logic         res_valid;
	wsfd_result_t res;

	assign stall    = out_valid_q && !out_ready;
	assign step     = valid_s1 && !stall;
	assign in_ready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
			last_s1 <= buffer_end;
		end
	end

	wsfd_parser #(
		.LEN_BITS (LEN_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.last      (last_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!stall)
			out_valid_q <= step && res_valid;
	end

	always_ff @(posedge clk) begin
		if (step && res_valid)
			out_q <= res;
	end

	assign out_valid  = out_valid_q;
	assign has_byte   = out_q.has_byte;
	assign data_byte  = out_q.data_byte;
	assign frame_end  = out_q.frame_end;
	assign frame_kind = out_q.frame_kind;
	assign frame_len  = out_q.frame_len;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && stall |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input register changed while the result side stalled");

	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> frame_end && data_byte == 8'd0)
		else $error("result with neither payload byte nor frame end");

	a_kind_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> frame_kind == KIND_TEXT && frame_len == '0)
		else $error("frame kind or length outside a frame end");

	a_too_long_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_kind == KIND_TOO_LONG |-> !has_byte && frame_len == '0)
		else $error("too long result carries data");

endmodule
`default_nettype wire

// ----- design/wsfd_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_parser
// Frame parse state and per-byte decode: header, extended length, mask key
// and payload unmasking, one byte per step.
// ----------------------------------------------------------------------------
module wsfd_parser #(
	parameter int LEN_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [7:0]           rx_byte,
	input  wire logic                 last,
	output logic                      res_valid,
	output wsfd_pkg::wsfd_result_t    res
);
	import wsfd_pkg::*;

	localparam logic [2:0] PH_HDR0 = 3'd0;
	localparam logic [2:0] PH_HDR1 = 3'd1;
	localparam logic [2:0] PH_EXT  = 3'd2;
	localparam logic [2:0] PH_MASK = 3'd3;
	localparam logic [2:0] PH_BODY = 3'd4;
	localparam logic [2:0] PH_SKIP = 3'd5;

	localparam int CW = (LEN_BITS < PLEN_W) ? LEN_BITS : PLEN_W;

	logic [2:0]          phase_q, phase_d;
	logic                fin_q, fin_d;
	logic [3:0]          op_q, op_d;
	logic                mask_en_q, mask_en_d;
	logic [3:0]          ext_left_q, ext_left_d;
	logic                ovf_q, ovf_d;
	logic [LEN_BITS-1:0] flen_q, flen_d;
	logic [LEN_BITS-1:0] cnt_q, cnt_d;
	logic [31:0]         key_q, key_d;

	logic                header_done, body_start, complete, too_long, skip;
	logic                has;
	logic [7:0]          data, key_byte;
	logic [PLEN_W-1:0]   flen32;

	assign flen32 = PLEN_W'(flen_d[CW-1:0]);

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d     = phase_q;
		fin_d       = fin_q;
		op_d        = op_q;
		mask_en_d   = mask_en_q;
		ext_left_d  = ext_left_q;
		ovf_d       = ovf_q;
		flen_d      = flen_q;
		cnt_d       = cnt_q;
		key_d       = key_q;
		header_done = 1'b0;
		body_start  = 1'b0;
		complete    = 1'b0;
		too_long    = 1'b0;
		skip        = 1'b0;
		has         = 1'b0;
		data        = '0;
		res_valid   = 1'b0;
		res         = '0;

		case (phase_q)
			PH_HDR0: begin
				fin_d      = rx_byte[7];
				op_d       = rx_byte[3:0];
				mask_en_d  = 1'b0;
				ext_left_d = '0;
				ovf_d      = 1'b0;
				flen_d     = '0;
				cnt_d      = '0;
				key_d      = '0;
				phase_d    = PH_HDR1;
			end
			PH_HDR1: begin
				mask_en_d = rx_byte[7];
				if (rx_byte[6:0] <= LEN7_MAX) begin
					flen_d      = LEN_BITS'(rx_byte[6:0]);
					header_done = 1'b1;
				end else begin
					ext_left_d = (rx_byte[6:0] == LEN7_EXT16) ? EXT_BYTES_16 : EXT_BYTES_64;
					phase_d    = PH_EXT;
				end
			end
			PH_EXT: begin
				// bits about to shift out of the length register
				if (flen_q[LEN_BITS-1 -: 8] != 8'd0)
					ovf_d = 1'b1;
				flen_d     = {flen_q[LEN_BITS-9:0], rx_byte};
				ext_left_d = ext_left_q - 4'd1;
				if (ext_left_d == 4'd0) begin
					if (ovf_d)
						too_long = 1'b1;
					else
						header_done = 1'b1;
				end
			end
			PH_MASK: begin
				key_d = {key_q[23:0], rx_byte};
				cnt_d = cnt_q + LEN_BITS'(1);
				if (cnt_q[1:0] == 2'd3)
					body_start = 1'b1;
			end
			PH_BODY: begin
				data  = rx_byte ^ key_byte;
				has   = 1'b1;
				cnt_d = cnt_q + LEN_BITS'(1);
				if (cnt_d == flen_q)
					complete = 1'b1;
			end
			default: begin
				// trailing bytes after a frame
				skip = 1'b1;
				if (last)
					phase_d = PH_HDR0;
			end
		endcase

		if (header_done) begin
			cnt_d = '0;
			if (mask_en_d)
				phase_d = PH_MASK;
			else
				body_start = 1'b1;
		end
		if (body_start) begin
			cnt_d = '0;
			if (flen_d == '0)
				complete = 1'b1;
			else
				phase_d = PH_BODY;
		end

		if (too_long) begin
			res_valid      = 1'b1;
			res.frame_end  = 1'b1;
			res.frame_kind = KIND_TOO_LONG;
			phase_d        = last ? PH_HDR0 : PH_SKIP;
		end else if (!skip) begin
			res.has_byte  = has;
			res.data_byte = data;
			if (complete) begin
				res_valid      = 1'b1;
				res.frame_end  = 1'b1;
				res.frame_kind = kind_of(fin_q, op_q);
				res.frame_len  = flen32;
				phase_d        = last ? PH_HDR0 : PH_SKIP;
			end else if (last) begin
				// buffer ran out mid-frame
				res_valid      = 1'b1;
				res.frame_end  = 1'b1;
				res.frame_kind = KIND_INCOMPLETE;
				if (phase_d == PH_MASK || phase_d == PH_BODY)
					res.frame_len = flen32;
				phase_d = PH_HDR0;
			end else begin
				res_valid = has;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR0;
			fin_q      <= 1'b0;
			op_q       <= '0;
			mask_en_q  <= 1'b0;
			ext_left_q <= '0;
			ovf_q      <= 1'b0;
			flen_q     <= '0;
			cnt_q      <= '0;
			key_q      <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			fin_q      <= fin_d;
			op_q       <= op_d;
			mask_en_q  <= mask_en_d;
			ext_left_q <= ext_left_d;
			ovf_q      <= ovf_d;
			flen_q     <= flen_d;
			cnt_q      <= cnt_d;
			key_q      <= key_d;
		end
	end

	a_ext_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_EXT |-> ext_left_q != 4'd0)
		else $error("extended length phase with no bytes left");

	a_body_count_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> cnt_q < flen_q)
		else $error("payload count reached frame length inside body");

	a_key_count_small: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MASK |-> cnt_q < LEN_BITS'(4))
		else $error("mask key count out of range");

endmodule
`default_nettype wire
